@@ src/nrbh_pkg.sv @@
// Package with the payload structs and constants of the nearest ray box hit block.
package nrbh_pkg;

   localparam int CoordWidth = 32;
   localparam int DistWidth  = 31;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [1:0] REG_BOXES_IN_USE = 2'd0;
   localparam logic [1:0] REG_NEAR_LIMIT   = 2'd1;
   localparam logic [1:0] REG_FAR_LIMIT    = 2'd2;

   localparam logic [6:0]  BOXES_RESET = 7'd0;
   localparam logic [30:0] NEAR_RESET  = 31'd2621;
   localparam logic [30:0] FAR_RESET   = 31'd72090;

   typedef struct packed {
      logic               mode;
      logic [5:0]         slot;
      logic               ignore_flag;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [30:0]        hit_distance;
      logic signed [31:0] impact_x;
      logic signed [31:0] impact_y;
      logic signed [31:0] impact_z;
   } rsp_type;

endpackage

@@ src/nearest_ray_box_hit_top.sv @@
// Top level of the nearest ray box hit block: box table, slab test sequencer and shared divider.
//
// A box load writes its table row in S_LOAD. A ray query walks table entries 0 to
// min(boxes_in_use, MAX_BOXES)-1 one at a time; every axis with a nonzero direction needs
// two quotients from one shared restoring divider that produces one quotient bit per cycle,
// and the impact point takes three more multiplier steps. busy stays high for the whole query.
// The result appears on rsp_data for a single cycle with rsp_valid high; the receiver
// cannot stall it and must take it in that cycle. No clearing pass follows reset.
module nearest_ray_box_hit_top #(
   parameter int MAX_BOXES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nrbh_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output nrbh_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CntW = $clog2(MAX_BOXES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_READ, S_WAIT, S_AXIS, S_DIV, S_DIVDONE, S_BOXEND,
      S_MUL, S_OUT
   } state_type;

   // Configuration registers.
   logic [6:0]  boxes_ff;
   logic [30:0] near_ff, far_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         boxes_ff <= nrbh_pkg::BOXES_RESET;
         near_ff  <= nrbh_pkg::NEAR_RESET;
         far_ff   <= nrbh_pkg::FAR_RESET;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            nrbh_pkg::REG_BOXES_IN_USE: boxes_ff <= pwdata[6:0];
            nrbh_pkg::REG_NEAR_LIMIT:   near_ff  <= pwdata[30:0];
            nrbh_pkg::REG_FAR_LIMIT:    far_ff   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         nrbh_pkg::REG_BOXES_IN_USE: prdata = {25'd0, boxes_ff};
         nrbh_pkg::REG_NEAR_LIMIT:   prdata = {1'b0, near_ff};
         nrbh_pkg::REG_FAR_LIMIT:    prdata = {1'b0, far_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // Box table: one row holds both corners and the ignore flag.
   logic [6*32:0] box_mem [MAX_BOXES];
   logic [6*32:0] row_ff;
   logic [IdxW-1:0] rd_addr;

   // Sequencer state.
   state_type   state_ff;
   nrbh_pkg::req_type req_ff;
   logic [CntW-1:0] idx_ff, count_ff;
   logic [1:0]  axis_ff;
   logic        second_ff;
   logic signed [63:0] tmin_ff, tmax_ff, t1_ff;
   logic        bounded_ff;
   logic        hit_ff;
   logic signed [63:0] best_ff;

   // Divider state.
   logic [63:0] dnum_ff, drem_ff, dden_ff;
   logic        dneg_ff;
   logic [6:0]  dcnt_ff;
   logic        rsp_valid_ff;
   nrbh_pkg::rsp_type rsp_ff;

   assign rd_addr = idx_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD && int'(req_ff.slot) < MAX_BOXES)
         box_mem[IdxW'(req_ff.slot)] <= {req_ff.ignore_flag, req_ff.a_x, req_ff.a_y,
            req_ff.a_z, req_ff.b_x, req_ff.b_y, req_ff.b_z};
      row_ff <= box_mem[rd_addr];
   end

   // Per-axis operands of the current box.
   logic signed [31:0] o_s, d_s, lo_s, hi_s;
   always_comb begin
      case (axis_ff)
         2'd0: begin
            o_s = req_ff.a_x; d_s = req_ff.b_x;
            lo_s = row_ff[191:160]; hi_s = row_ff[95:64];
         end
         2'd1: begin
            o_s = req_ff.a_y; d_s = req_ff.b_y;
            lo_s = row_ff[159:128]; hi_s = row_ff[63:32];
         end
         default: begin
            o_s = req_ff.a_z; d_s = req_ff.b_z;
            lo_s = row_ff[127:96]; hi_s = row_ff[31:0];
         end
      endcase
   end

   logic signed [63:0] diff_s, numer_s;
   logic [63:0] num_mag, den_mag;
   logic signed [63:0] quot_s;
   logic [64:0] trial;
   logic signed [63:0] t_lo, t_hi, new_tmin, new_tmax;
   logic [CntW-1:0] count_in;

   assign diff_s  = 64'(second_ff ? hi_s : lo_s) - 64'(o_s);
   assign numer_s = diff_s <<< FRAC_BITS;
   assign num_mag = numer_s[63] ? 64'(-numer_s) : 64'(numer_s);
   assign den_mag = d_s[31] ? 64'(-64'(d_s)) : 64'(d_s);
   assign trial   = {drem_ff, dnum_ff[63]} - {1'b0, dden_ff};
   assign quot_s  = dneg_ff ? -$signed(dnum_ff) : $signed(dnum_ff);
   assign t_lo    = (t1_ff > quot_s) ? quot_s : t1_ff;
   assign t_hi    = (t1_ff > quot_s) ? t1_ff : quot_s;
   assign new_tmin = (t_lo > tmin_ff) ? t_lo : tmin_ff;
   assign new_tmax = (!bounded_ff || t_hi < tmax_ff) ? t_hi : tmax_ff;
   assign count_in = (int'(boxes_ff) > MAX_BOXES) ? CntW'(MAX_BOXES) : CntW'(boxes_ff);

   // Impact point: one multiplier, one axis per cycle.
   logic signed [63:0] prod_s, fl_s, sum_s;
   logic signed [31:0] mul_d, mul_o, sat_s;
   always_comb begin
      case (axis_ff)
         2'd0:    begin mul_d = req_ff.b_x; mul_o = req_ff.a_x; end
         2'd1:    begin mul_d = req_ff.b_y; mul_o = req_ff.a_y; end
         default: begin mul_d = req_ff.b_z; mul_o = req_ff.a_z; end
      endcase
   end
   assign prod_s = 64'(mul_d) * $signed({1'b0, best_ff[30:0]});
   assign fl_s   = prod_s >>> FRAC_BITS;
   assign sum_s  = 64'(mul_o) + fl_s;
   assign sat_s  = (sum_s > 64'sd2147483647) ? 32'sh7fffffff :
                   (sum_s < -64'sd2147483648) ? 32'sh80000000 : sum_s[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  idx_ff   <= '0;
                  count_ff <= count_in;
                  hit_ff   <= 1'b0;
                  best_ff  <= 64'(far_ff);
                  state_ff <= (req_data.mode == nrbh_pkg::MODE_LOAD) ? S_LOAD : S_READ;
               end
            end
            S_LOAD: state_ff <= S_IDLE;
            S_READ: begin
               if (idx_ff == count_ff) begin
                  axis_ff  <= 2'd0;
                  state_ff <= hit_ff ? S_MUL : S_OUT;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               axis_ff    <= 2'd0;
               second_ff  <= 1'b0;
               tmin_ff    <= '0;
               tmax_ff    <= '0;
               bounded_ff <= 1'b0;
               state_ff   <= row_ff[192] ? S_BOXEND : S_AXIS;
               if (row_ff[192]) idx_ff <= idx_ff + 1'b1;
            end
            S_AXIS: begin
               if (axis_ff == 2'd3) begin
                  if (!(bounded_ff && tmax_ff < 0) && tmin_ff > 64'(near_ff)
                      && tmin_ff < best_ff) begin
                     best_ff <= tmin_ff;
                     hit_ff  <= 1'b1;
                  end
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_BOXEND;
               end else if (d_s == 32'sd0) begin
                  if (o_s < lo_s || o_s > hi_s) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_BOXEND;
                  end else begin
                     axis_ff <= axis_ff + 2'd1;
                  end
               end else begin
                  dnum_ff  <= num_mag;
                  drem_ff  <= '0;
                  dden_ff  <= den_mag;
                  dneg_ff  <= numer_s[63] ^ d_s[31];
                  dcnt_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (trial[64]) begin
                  drem_ff <= {drem_ff[62:0], dnum_ff[63]};
                  dnum_ff <= {dnum_ff[62:0], 1'b0};
               end else begin
                  drem_ff <= trial[63:0];
                  dnum_ff <= {dnum_ff[62:0], 1'b1};
               end
               dcnt_ff <= dcnt_ff + 7'd1;
               if (dcnt_ff == 7'd63) state_ff <= S_DIVDONE;
            end
            S_DIVDONE: begin
               if (!second_ff) begin
                  t1_ff     <= quot_s;
                  second_ff <= 1'b1;
                  state_ff  <= S_AXIS;
               end else begin
                  second_ff  <= 1'b0;
                  tmin_ff    <= new_tmin;
                  tmax_ff    <= new_tmax;
                  bounded_ff <= 1'b1;
                  if (new_tmin > new_tmax) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_BOXEND;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= S_AXIS;
                  end
               end
            end
            S_BOXEND: state_ff <= S_READ;
            S_MUL: begin
               case (axis_ff)
                  2'd0:    rsp_ff.impact_x <= sat_s;
                  2'd1:    rsp_ff.impact_y <= sat_s;
                  default: rsp_ff.impact_z <= sat_s;
               endcase
               axis_ff <= axis_ff + 2'd1;
               if (axis_ff == 2'd2) state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_ff.hit          <= hit_ff;
               rsp_ff.hit_distance <= hit_ff ? best_ff[30:0] : 31'd0;
               if (!hit_ff) begin
                  rsp_ff.impact_x <= '0;
                  rsp_ff.impact_y <= '0;
                  rsp_ff.impact_z <= '0;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_OUT) else $error("result without finish");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> idx_ff <= count_ff) else $error("box index overrun");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVDONE |-> $past(state_ff) == S_DIV) else $error("divider done early");
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.hit_distance > near_ff)
      else $error("hit inside near limit");

endmodule

@@ bench/nearest_ray_box_hit_top_test.sv @@
// Testbench for the nearest ray box hit block: box loads and ray queries checked by a scoreboard.
`timescale 1ns / 1ps

module nearest_ray_box_hit_top_test;

   localparam int TableDepth = 64;
   localparam int StallLimit = 200000;
   localparam int RandomItems = 560;

   class hit_scoreboard;
      int box_lo[TableDepth][3];
      int box_hi[TableDepth][3];
      bit box_ignored[TableDepth];
      logic [6:0] boxes_in_use;
      logic [30:0] near_limit;
      logic [30:0] far_limit;
      nrbh_pkg::rsp_type expected_hits[$];
      int errors;
      int loads;
      int queries;
      int hits;

      function new();
         boxes_in_use = nrbh_pkg::BOXES_RESET;
         near_limit = nrbh_pkg::NEAR_RESET;
         far_limit = nrbh_pkg::FAR_RESET;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            nrbh_pkg::REG_BOXES_IN_USE: boxes_in_use = value[6:0];
            nrbh_pkg::REG_NEAR_LIMIT: near_limit = value[30:0];
            nrbh_pkg::REG_FAR_LIMIT: far_limit = value[30:0];
            default: ;
         endcase
      endfunction

      function nrbh_pkg::rsp_type nearest_hit(nrbh_pkg::req_type r);
         longint o[3], d[3], lo, hi, t1, t2, tmin, tmax, best, p;
         int count;
         bit ok, bounded, found;
         nrbh_pkg::rsp_type res;
         o[0] = r.a_x; o[1] = r.a_y; o[2] = r.a_z;
         d[0] = r.b_x; d[1] = r.b_y; d[2] = r.b_z;
         count = (boxes_in_use > TableDepth) ? TableDepth : boxes_in_use;
         best = far_limit;
         found = 0;
         for (int i = 0; i < count; i++) begin
            if (!box_ignored[i]) begin
               ok = 1;
               bounded = 0;
               tmin = 0;
               tmax = 0;
               for (int ax = 0; ax < 3; ax++) begin
                  if (ok) begin
                     lo = box_lo[i][ax];
                     hi = box_hi[i][ax];
                     if (d[ax] == 0) begin
                        if (o[ax] < lo || o[ax] > hi) ok = 0;
                     end else begin
                        t1 = ((lo - o[ax]) * 65536) / d[ax];
                        t2 = ((hi - o[ax]) * 65536) / d[ax];
                        if (t1 > t2) begin
                           p = t1; t1 = t2; t2 = p;
                        end
                        if (t1 > tmin) tmin = t1;
                        if (!bounded || t2 < tmax) begin
                           tmax = t2;
                           bounded = 1;
                        end
                        if (tmin > tmax) ok = 0;
                     end
                  end
               end
               if (ok && bounded && tmax < 0) ok = 0;
               if (ok && tmin > longint'(near_limit) && tmin < best) begin
                  best = tmin;
                  found = 1;
               end
            end
         end
         res = '0;
         if (found) begin
            res.hit = 1'b1;
            res.hit_distance = best[30:0];
            for (int ax = 0; ax < 3; ax++) begin
               p = o[ax] + ((d[ax] * best) >>> 16);
               if (p > 64'sd2147483647) p = 64'sd2147483647;
               if (p < -64'sd2147483648) p = -64'sd2147483648;
               if (ax == 0) res.impact_x = p[31:0];
               else if (ax == 1) res.impact_y = p[31:0];
               else res.impact_z = p[31:0];
            end
         end
         return res;
      endfunction

      function void note_request(nrbh_pkg::req_type r);
         if (r.mode == nrbh_pkg::MODE_LOAD) begin
            box_lo[r.slot] = '{r.a_x, r.a_y, r.a_z};
            box_hi[r.slot] = '{r.b_x, r.b_y, r.b_z};
            box_ignored[r.slot] = r.ignore_flag;
            loads++;
         end else begin
            expected_hits.push_back(nearest_hit(r));
            queries++;
         end
      endfunction

      function void compare(string name, longint e, longint a);
         if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(nrbh_pkg::rsp_type got);
         nrbh_pkg::rsp_type e;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result transfer %h", $time, got);
            errors++;
         end else begin
            e = expected_hits.pop_front();
            if (got.hit) hits++;
            compare("hit", e.hit, got.hit);
            compare("hit_distance", e.hit_distance, got.hit_distance);
            compare("impact_x", e.impact_x, got.impact_x);
            compare("impact_y", e.impact_y, got.impact_y);
            compare("impact_z", e.impact_z, got.impact_z);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   nrbh_pkg::req_type req_data;
   logic rsp_valid;
   nrbh_pkg::rsp_type rsp_data;
   logic psel, penable, pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   hit_scoreboard sb = new();
   int stall_cycles;
   int sender_idle_pct;

   nearest_ray_box_hit_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("nearest_ray_box_hit_top_test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send(input nrbh_pkg::req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (sb.expected_hits.size() != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(index, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(input int boxes, input int near_d, input int far_d);
      settle();
      csr_write(nrbh_pkg::REG_BOXES_IN_USE, boxes);
      csr_write(nrbh_pkg::REG_NEAR_LIMIT, near_d);
      csr_write(nrbh_pkg::REG_FAR_LIMIT, far_d);
   endtask

   function automatic int near_coord();
      return int'($urandom_range(262144)) - 131072;
   endfunction

   function automatic int dir_coord();
      if ($urandom_range(3) == 0) return 0;
      return int'($urandom_range(131072)) - 65536;
   endfunction

   function automatic nrbh_pkg::req_type make_box(input int slot);
      nrbh_pkg::req_type r;
      r.mode = nrbh_pkg::MODE_LOAD;
      r.slot = 6'(slot);
      r.ignore_flag = ($urandom_range(7) == 0);
      if ($urandom_range(9) == 0) begin
         r.a_x = $urandom; r.a_y = $urandom; r.a_z = $urandom;
         r.b_x = $urandom; r.b_y = $urandom; r.b_z = $urandom;
      end else begin
         r.a_x = near_coord(); r.a_y = near_coord(); r.a_z = near_coord();
         r.b_x = r.a_x + int'($urandom_range(98304)) - 8192;
         r.b_y = r.a_y + int'($urandom_range(98304)) - 8192;
         r.b_z = r.a_z + int'($urandom_range(98304)) - 8192;
      end
      return r;
   endfunction

   function automatic nrbh_pkg::req_type make_ray();
      nrbh_pkg::req_type r;
      r.mode = nrbh_pkg::MODE_QUERY;
      r.slot = 6'($urandom);
      r.ignore_flag = 1'($urandom);
      if ($urandom_range(9) == 0) begin
         r.a_x = $urandom; r.a_y = $urandom; r.a_z = $urandom;
         r.b_x = $urandom; r.b_y = $urandom; r.b_z = $urandom;
      end else begin
         r.a_x = near_coord(); r.a_y = near_coord(); r.a_z = near_coord();
         r.b_x = dir_coord(); r.b_y = dir_coord(); r.b_z = dir_coord();
      end
      return r;
   endfunction

   function automatic nrbh_pkg::req_type item(input logic m, input int s, input logic ign,
                                              input int ax, input int ay, input int az,
                                              input int bx, input int by, input int bz);
      nrbh_pkg::req_type r;
      r = '{m, s[5:0], ign, ax, ay, az, bx, by, bz};
      return r;
   endfunction

   initial begin
      int boxes, near_d, far_d, phase_items, sent;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      sender_idle_pct = 25;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset settings no box is tested, so the query misses.
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 65536, 0, 0));
      send(item(nrbh_pkg::MODE_LOAD, 0, 0, -65536, -65536, -65536, 65536, 65536, 65536));
      send(item(nrbh_pkg::MODE_LOAD, 1, 1, -65536, -65536, -65536, 65536, 65536, 65536));
      send(item(nrbh_pkg::MODE_LOAD, 2, 0, -65536, -65536, -65536, 65536, 65536, 65536));
      send(item(nrbh_pkg::MODE_LOAD, 3, 0, 196608, 65536, 65536, 131072, -65536, -65536));
      send(item(nrbh_pkg::MODE_LOAD, 4, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send(item(nrbh_pkg::MODE_LOAD, 63, 1, 32'h7fff_ffff, 32'h8000_0000, 0,
                32'h8000_0000, 0, -1));
      configure(4, 0, 32'h7fff_ffff);
      csr_write(2'd3, 32'hffff_ffff);
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, -131072, 0, 0, 65536, 0, 0));
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, -131072, 200000, 0, 65536, 0, 0));
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 300000, 0, 0, -65536, 0, 0));
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 300000, 0, 0, 65536, 0, 0));
      configure(5, 0, 32'h7fff_ffff);
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, 32'h7fff_ffff, -1, 0, 32'h0001_0000,
                32'h7fff_ffff, -1));
      configure(5, 32'h7fff_ffff, 32'h7fff_ffff);
      send(item(nrbh_pkg::MODE_QUERY, 0, 0, -131072, 0, 0, 65536, 0, 0));

      // Fill the whole table so that any count can be queried from here on.
      sent = 0;
      for (int s = 0; s < TableDepth; s++) begin
         send(make_box(s));
         sent++;
      end
      for (int p = 0; sent < RandomItems; p++) begin
         phase_items = 40;
         near_d = $urandom_range(20000);
         far_d = $urandom_range(450000, near_d + 1);
         boxes = $urandom_range(8, 1);
         if (p == 0) begin
            boxes = 64; near_d = 0; far_d = 32'h7fff_ffff; phase_items = 8;
         end else if (p == 1) begin
            boxes = 127; near_d = nrbh_pkg::NEAR_RESET; far_d = nrbh_pkg::FAR_RESET;
            phase_items = 6;
         end else if (p == 2) begin
            boxes = 5; near_d = 100000; far_d = 100000;
         end else if (p == 3) begin
            boxes = 0; near_d = 0; far_d = 0;
         end else if (p % 4 == 0) begin
            far_d = $urandom >> 1;
         end
         configure(boxes, near_d, far_d);
         for (int k = 0; k < phase_items && sent < RandomItems; k++) begin
            if (sent < RandomItems / 3) sender_idle_pct = 25;
            else if (sent < 2 * RandomItems / 3) sender_idle_pct = 87;
            else sender_idle_pct = 0;
            if ($urandom_range(99) < 55) send(make_box($urandom_range(TableDepth - 1)));
            else send(make_ray());
            sent++;
         end
      end
      settle();
      repeat (20) @(posedge clock);

      $display("Covered %0d box loads and %0d ray queries, %0d of which hit a box.",
               sb.loads, sb.queries, sb.hits);
      if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
         $display("nearest_ray_box_hit_top_test passed");
      end else begin
         $display("nearest_ray_box_hit_top_test failed");
      end
      $finish;
   end

endmodule
